FILE: rtl/dtt_pkg.sv
package dtt_pkg;

  // Tile grid geometry
  localparam int TILE_SIZE     = 128;
  localparam int TILE_LOG2     = $clog2(TILE_SIZE);
  localparam int MAX_TILE_COLS = 8;
  localparam int MAX_TILE_ROWS = 8;
  localparam int MAP_DEPTH     = MAX_TILE_COLS * MAX_TILE_ROWS;
  localparam int MAP_IW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int RESULT_CAP    = 64;
  localparam int CNT_W         = $clog2(RESULT_CAP + 1);

  // Pixel math is 13 bits wide: holds x + w - 1 for 12-bit x and w
  localparam int PIX_W = 13;
  localparam int CRD_W = PIX_W - TILE_LOG2;
  localparam int IDX_W = 2 * CRD_W;
  localparam int SCR_W = 11;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACKING_ON   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;
  localparam logic [SCR_W-1:0]     SCREEN_RESET      = 11'd1024;

  // Operation codes
  localparam logic [1:0] OP_MARK_RECT = 2'd0;
  localparam logic [1:0] OP_MARK_ALL  = 2'd1;
  localparam logic [1:0] OP_FLIP      = 2'd2;
  localparam logic [1:0] OP_QUERY     = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_COPY   = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] rect_x;
    logic [11:0] rect_y;
    logic [11:0] rect_width;
    logic [11:0] rect_height;
  } dtt_in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [9:0]       copy_x;
    logic [9:0]       copy_y;
    logic [SCR_W-1:0] copy_width;
    logic [SCR_W-1:0] copy_height;
    logic             any_dirty;
    logic             last;
  } dtt_out_t;

  // Walker control from the sequencer
  typedef struct packed {
    logic             start;
    logic             step;
    logic [CRD_W-1:0] tx_lo;
    logic [CRD_W-1:0] tx_hi;
    logic [CRD_W-1:0] ty_lo;
    logic [CRD_W-1:0] ty_hi;
  } walk_ctrl_t;

  // Walker status: current tile and its clipped region
  typedef struct packed {
    logic              at_end;
    logic              in_map;
    logic [MAP_IW-1:0] midx;
    logic [9:0]        px;
    logic [9:0]        py;
    logic [SCR_W-1:0]  tw;
    logic [SCR_W-1:0]  th;
  } walk_stat_t;

endpackage

FILE: rtl/dtt_walker.sv
module dtt_walker (
  input  logic                     clk,
  input  dtt_pkg::walk_ctrl_t      ctrl,
  input  logic [dtt_pkg::CRD_W-1:0] cols,
  input  logic [dtt_pkg::SCR_W-1:0] screen_w,
  input  logic [dtt_pkg::SCR_W-1:0] screen_h,
  output dtt_pkg::walk_stat_t      stat
);
  import dtt_pkg::*;

  logic [CRD_W-1:0] tx_r, ty_r, tx_lo_r, tx_hi_r, ty_hi_r;
  logic [IDX_W-1:0] idx;
  logic [PIX_W-1:0] px, py, tw, th;
  logic             row_end;

  assign row_end = (tx_r == tx_hi_r);

  // Row-major tile walk
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      tx_r    <= ctrl.tx_lo;
      ty_r    <= ctrl.ty_lo;
      tx_lo_r <= ctrl.tx_lo;
      tx_hi_r <= ctrl.tx_hi;
      ty_hi_r <= ctrl.ty_hi;
    end else if (ctrl.step) begin
      if (row_end) begin
        tx_r <= tx_lo_r;
        ty_r <= ty_r + CRD_W'(1);
      end else begin
        tx_r <= tx_r + CRD_W'(1);
      end
    end
  end

  always_comb begin
    idx = IDX_W'(ty_r) * IDX_W'(cols) + IDX_W'(tx_r);
    px  = PIX_W'(tx_r) << TILE_LOG2;
    py  = PIX_W'(ty_r) << TILE_LOG2;
    // clip at the right and bottom screen edges
    tw  = (px + PIX_W'(TILE_SIZE) > PIX_W'(screen_w)) ? PIX_W'(screen_w) - px
                                                       : PIX_W'(TILE_SIZE);
    th  = (py + PIX_W'(TILE_SIZE) > PIX_W'(screen_h)) ? PIX_W'(screen_h) - py
                                                       : PIX_W'(TILE_SIZE);
    stat.at_end = row_end && (ty_r == ty_hi_r);
    stat.in_map = (idx < IDX_W'(MAP_DEPTH));
    stat.midx   = idx[MAP_IW-1:0];
    stat.px     = px[9:0];
    stat.py     = py[9:0];
    stat.tw     = tw[SCR_W-1:0];
    stat.th     = th[SCR_W-1:0];
  end

endmodule

FILE: rtl/dirty_tile_tracker_top.sv
// Dirty tile tracker: one dirty bit per screen tile, walked by a tile sequencer.
// Input channel (in_valid / in_stall, payload in_data): one operation per transfer
// (mark rectangle, mark all, flip, query). The block takes a new operation only
// while its sequencer is idle and the output register is free or draining.
// Result channel (out_valid / out_stall, payload out_data): query and untracked
// flip give one result, registered, in the cycle after acceptance. A tracked
// flip walks the cols * rows tiles (up to 64) one tile per cycle, pausing while a
// dirty tile waits on a stalled output register, and ends in a finish state. It gives
// one copy command per dirty tile, the last result carries last = 1, and a flip
// with no dirty tile gives one "nothing to copy" marker.
// Mark rectangle walks the touched tiles and sets their bits, mark all sets the
// whole map without a walk; neither gives a result, and both act only while
// tracking. Mark and flip share one tile walker with its index and clip unit.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready.
// Reset (rst_n, synchronous, active low) clears the dirty map, turns tracking
// off and sets the screen to 1024 x 1024.
// A stalled receiver freezes the output register; the walk waits on it.
module dirty_tile_tracker_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  dtt_pkg::dtt_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output dtt_pkg::dtt_out_t            out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dtt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dtt_pkg::SCR_W-1:0]    cfg_data
);
  import dtt_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MARK   = 2'd1;
  localparam logic [1:0] ST_FLIP   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic                 tracking_r;
  logic [SCR_W-1:0]     sw_r, sh_r;
  logic [MAP_DEPTH-1:0] map_r, map_nxt;
  logic                 any_r, any_nxt;
  dtt_out_t             held_r, held_nxt;
  logic                 held_valid_r, held_valid_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  dtt_out_t             out_data_r, out_data_nxt;

  walk_ctrl_t           wctrl;
  walk_stat_t           wstat;

  logic                 in_xfer, out_free, load, hit;
  dtt_out_t             load_data, tile_res;
  logic [CRD_W-1:0]     cols, rows, cols_raw, rows_raw;
  logic [CRD_W-1:0]     tx0, ty0, tx1, ty1, tx1_raw, ty1_raw;
  logic [PIX_W-1:0]     x_end, y_end;
  logic                 rect_ok;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Grid size: ceil(size / tile), clamped to the map
  always_comb begin
    cols_raw = CRD_W'((PIX_W'(sw_r) + PIX_W'(TILE_SIZE - 1)) >> TILE_LOG2);
    rows_raw = CRD_W'((PIX_W'(sh_r) + PIX_W'(TILE_SIZE - 1)) >> TILE_LOG2);
    cols     = (cols_raw > CRD_W'(MAX_TILE_COLS)) ? CRD_W'(MAX_TILE_COLS) : cols_raw;
    rows     = (rows_raw > CRD_W'(MAX_TILE_ROWS)) ? CRD_W'(MAX_TILE_ROWS) : rows_raw;
  end

  // Tile bounds of the rectangle, far edge clamped to the grid
  always_comb begin
    x_end   = PIX_W'(in_data.rect_x) + PIX_W'(in_data.rect_width) - PIX_W'(1);
    y_end   = PIX_W'(in_data.rect_y) + PIX_W'(in_data.rect_height) - PIX_W'(1);
    tx0     = CRD_W'(PIX_W'(in_data.rect_x) >> TILE_LOG2);
    ty0     = CRD_W'(PIX_W'(in_data.rect_y) >> TILE_LOG2);
    tx1_raw = CRD_W'(x_end >> TILE_LOG2);
    ty1_raw = CRD_W'(y_end >> TILE_LOG2);
    tx1     = (tx1_raw >= cols) ? cols - CRD_W'(1) : tx1_raw;
    ty1     = (ty1_raw >= rows) ? rows - CRD_W'(1) : ty1_raw;
    // start beyond the grid (wide screen setting) starts no walk
    rect_ok = tracking_r && (in_data.rect_width != '0) && (in_data.rect_height != '0)
              && (in_data.rect_x < 12'(sw_r)) && (in_data.rect_y < 12'(sh_r))
              && (cols != '0) && (rows != '0) && (tx0 <= tx1) && (ty0 <= ty1);
  end

  dtt_walker u_walker (
    .clk      (clk),
    .ctrl     (wctrl),
    .cols     (cols),
    .screen_w (sw_r),
    .screen_h (sh_r),
    .stat     (wstat)
  );

  always_comb begin
    tile_res             = '0;
    tile_res.kind        = KIND_COPY;
    tile_res.copy_x      = wstat.px;
    tile_res.copy_y      = wstat.py;
    tile_res.copy_width  = wstat.tw;
    tile_res.copy_height = wstat.th;
    hit = wstat.in_map && map_r[wstat.midx] && (cnt_r < CNT_W'(RESULT_CAP));
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    map_nxt        = map_r;
    any_nxt        = any_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    cnt_nxt        = cnt_r;
    load           = 1'b0;
    load_data      = '0;
    wctrl          = '0;
    wctrl.tx_lo    = tx0;
    wctrl.tx_hi    = tx1;
    wctrl.ty_lo    = ty0;
    wctrl.ty_hi    = ty1;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_data.operation)
            OP_MARK_RECT: begin
              if (rect_ok) begin
                wctrl.start = 1'b1;
                state_nxt   = ST_MARK;
              end
            end
            OP_MARK_ALL: begin
              if (tracking_r) begin
                map_nxt = '1;
                any_nxt = 1'b1;
              end
            end
            OP_FLIP: begin
              if (!tracking_r) begin
                load                  = 1'b1;
                load_data.kind        = KIND_COPY;
                load_data.copy_width  = sw_r;
                load_data.copy_height = sh_r;
                load_data.last        = 1'b1;
              end else begin
                held_valid_nxt = 1'b0;
                cnt_nxt        = '0;
                if ((cols != '0) && (rows != '0)) begin
                  wctrl.start = 1'b1;
                  wctrl.tx_lo = '0;
                  wctrl.ty_lo = '0;
                  wctrl.tx_hi = cols - CRD_W'(1);
                  wctrl.ty_hi = rows - CRD_W'(1);
                  state_nxt   = ST_FLIP;
                end else begin
                  state_nxt = ST_FINISH;
                end
              end
            end
            default: begin
              load                = 1'b1;
              load_data.kind      = KIND_STATUS;
              load_data.any_dirty = any_r;
              load_data.last      = 1'b1;
            end
          endcase
        end
      end
      ST_MARK: begin
        if (wstat.in_map) begin
          map_nxt[wstat.midx] = 1'b1;
          any_nxt             = 1'b1;
        end
        wctrl.step = 1'b1;
        if (wstat.at_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLIP: begin
        // one tile is held back so the final one can carry last
        if (hit && held_valid_r) begin
          if (out_free) begin
            load       = 1'b1;
            load_data  = held_r;
            held_nxt   = tile_res;
            cnt_nxt    = cnt_r + CNT_W'(1);
            wctrl.step = 1'b1;
            if (wstat.at_end) begin
              state_nxt = ST_FINISH;
            end
          end
        end else begin
          if (hit) begin
            held_nxt       = tile_res;
            held_valid_nxt = 1'b1;
            cnt_nxt        = cnt_r + CNT_W'(1);
          end
          wctrl.step = 1'b1;
          if (wstat.at_end) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          load = 1'b1;
          if (held_valid_r) begin
            load_data      = held_r;
            load_data.last = 1'b1;
          end else begin
            load_data.kind = KIND_NONE;
            load_data.last = 1'b1;
          end
          held_valid_nxt = 1'b0;
          map_nxt        = '0;
          any_nxt        = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = load_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tracking_r   <= 1'b0;
      sw_r         <= SCREEN_RESET;
      sh_r         <= SCREEN_RESET;
      map_r        <= '0;
      any_r        <= 1'b0;
      held_valid_r <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      map_r        <= map_nxt;
      any_r        <= any_nxt;
      held_valid_r <= held_valid_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TRACKING_ON:   tracking_r <= cfg_data[0];
          CFG_SCREEN_WIDTH:  sw_r       <= cfg_data;
          CFG_SCREEN_HEIGHT: sh_r       <= cfg_data;
          default:           ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
